// ===== rtl/core/ctcgd_pkg.sv =====
// Shared types and constants for the CTC greedy decoder.
package ctcgd_pkg;

  localparam int MAX_CLASSES = 8192;
  localparam int IDX_W       = 13;
  localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
  localparam int SCORE_W     = 16;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      step_end;
    logic                      sequence_end;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] char_index;
    logic             has_char;
    logic             text_end;
  } out_item_t;

  // One closed time step: its winning label and whether it ends the sequence.
  typedef struct packed {
    logic [IDX_W-1:0] label;
    logic             seq_end;
  } step_rec_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// ===== rtl/core/ctcgd_front.sv =====
// Front part: running argmax over the scores of a step; pushes one record per closed step.
module ctcgd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ctcgd_pkg::in_item_t in_data,
  output logic                in_stall,
  input  ctcgd_pkg::q_stat_t  q_stat,
  output logic                push,
  output ctcgd_pkg::step_rec_t push_rec
);
  import ctcgd_pkg::*;

  logic signed [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [IDX_W-1:0]          best_index_r, best_index_nxt;
  logic [CNT_W-1:0]          class_count_r, class_count_nxt;

  logic             accept;
  logic             in_range;
  logic             take;
  logic             close;
  logic [IDX_W-1:0] cur_index;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign in_range = class_count_r < CNT_W'(MAX_CLASSES);
  assign take     = in_range && ((class_count_r == '0) || (in_data.score > best_score_r));
  assign cur_index = take ? class_count_r[IDX_W-1:0] : best_index_r;
  // A sequence end closes its step even without a step end marker.
  assign close    = in_data.step_end || in_data.sequence_end;

  assign push             = accept && close;
  assign push_rec.label   = cur_index;
  assign push_rec.seq_end = in_data.sequence_end;

  always_comb begin
    best_score_nxt  = best_score_r;
    best_index_nxt  = best_index_r;
    class_count_nxt = class_count_r;
    if (accept) begin
      if (close) begin
        best_score_nxt  = '0;
        best_index_nxt  = '0;
        class_count_nxt = '0;
      end else if (in_range) begin
        if (take) begin
          best_score_nxt = in_data.score;
          best_index_nxt = class_count_r[IDX_W-1:0];
        end
        class_count_nxt = class_count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r  <= '0;
      best_index_r  <= '0;
      class_count_r <= '0;
    end else begin
      best_score_r  <= best_score_nxt;
      best_index_r  <= best_index_nxt;
      class_count_r <= class_count_nxt;
    end
  end

endmodule

// ===== rtl/core/ctcgd_queue.sv =====
// Short queue of closed-step records between the front and back parts.
module ctcgd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ctcgd_pkg::step_rec_t push_rec,
  input  logic                 pop,
  output ctcgd_pkg::step_rec_t pop_rec,
  output ctcgd_pkg::q_stat_t   stat
);
  import ctcgd_pkg::*;

  step_rec_t         entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign stat.full  = count_r == QCNT_W'(QDEPTH);
  assign stat.valid = count_r != '0;
  assign pop_rec    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/ctcgd_back.sv =====
// Back part: CTC collapse of closed steps and the output register.
module ctcgd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctcgd_pkg::q_stat_t   q_stat,
  input  ctcgd_pkg::step_rec_t q_rec,
  output logic                 pop,
  output logic                 out_valid,
  output ctcgd_pkg::out_item_t out_data,
  input  logic                 out_stall
);
  import ctcgd_pkg::*;

  logic [IDX_W-1:0] prev_label_r, prev_label_nxt;
  logic             first_step_r, first_step_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic slot_free;
  logic emit;
  logic result;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = q_stat.valid && slot_free;
  // Blanks and repeats of the previous step's label are dropped.
  assign emit      = (q_rec.label != '0) && (first_step_r || (q_rec.label != prev_label_r));
  assign result    = emit || q_rec.seq_end;

  always_comb begin
    prev_label_nxt = prev_label_r;
    first_step_nxt = first_step_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      prev_label_nxt = q_rec.seq_end ? '0 : q_rec.label;
      first_step_nxt = q_rec.seq_end;
      if (result) begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.char_index = emit ? q_rec.label - IDX_W'(1) : '0;
        out_data_nxt.has_char   = emit;
        out_data_nxt.text_end   = q_rec.seq_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_label_r <= '0;
      first_step_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      prev_label_r <= prev_label_nxt;
      first_step_r <= first_step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/ctc_greedy_decoder_core.sv =====
// Top level of the CTC greedy decoder: front argmax, step queue, back collapse.
//
// The decoder takes one class score per clock, unless in_stall holds it, and
// keeps a running argmax per time step (first score wins, ties keep the lower
// class). When a step closes, its label goes into a four-entry queue; the back
// part collapses blanks and repeats and registers at most one result per step,
// with text_end on the step that ends a sequence. The closing score's record
// passes through a queue entry, then the result through the output register.
// The input stalls only when four closed steps are waiting behind a stalled
// output. Scores at class position 8192 or above are ignored.
module ctc_greedy_decoder_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  ctcgd_pkg::in_item_t  in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output ctcgd_pkg::out_item_t out_data,
  input  logic                 out_stall
);
  import ctcgd_pkg::*;

  logic      q_push;
  logic      q_pop;
  step_rec_t q_push_rec;
  step_rec_t q_pop_rec;
  q_stat_t   q_stat;

  ctcgd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_rec (q_push_rec)
  );

  ctcgd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_push_rec),
    .pop      (q_pop),
    .pop_rec  (q_pop_rec),
    .stat     (q_stat)
  );

  ctcgd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rec     (q_pop_rec),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // The front never writes a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("step queue written while full");

  // A result without a character only ever ends a sequence.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_char |-> out_data.text_end && (out_data.char_index == '0))
    else $error("result without character outside sequence end");

  // A character index never comes from the blank label.
  a_no_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.has_char |-> out_data.char_index != {IDX_W{1'b1}})
    else $error("blank label emitted as character");

  // Popping needs a stored step record.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.valid)
    else $error("step queue read while empty");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the CTC greedy decoder core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ctcgd_pkg::*;

  typedef struct {
    in_item_t item;
    bit       hold;
  } pend_beat_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      out_stall = 1'b0;

  ctc_greedy_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  pend_beat_t pending[$];
  out_item_t  expected_chars[$];
  bit         hold_next = 1'b0;

  // Decoder state as the testbench sees it.
  logic signed [SCORE_W-1:0] arg_best_score = '0;
  logic [IDX_W-1:0]          arg_best_class = '0;
  logic [CNT_W-1:0]          class_pos = '0;
  logic [IDX_W-1:0]          last_label = '0;
  bit                        fresh_text = 1'b1;

  int errors = 0;
  int n_total = 0;
  int n_items = 0;
  int n_texts = 0;
  int n_results = 0;
  int n_chars = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;
  out_item_t exp_r;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Running argmax per step, then blank and repeat collapse when the step closes.
  task automatic decode_score(input in_item_t it);
    logic [IDX_W-1:0] label;
    logic             emit;
    out_item_t        res;
    if (class_pos < MAX_CLASSES) begin
      if (class_pos == 0 || it.score > arg_best_score) begin
        arg_best_score = it.score;
        arg_best_class = class_pos[IDX_W-1:0];
      end
      class_pos++;
    end
    if (it.step_end || it.sequence_end) begin
      label = arg_best_class;
      emit = (label != 0) && (fresh_text || label != last_label);
      last_label = label;
      fresh_text = 1'b0;
      class_pos = '0;
      arg_best_class = '0;
      arg_best_score = '0;
      if (it.sequence_end) begin
        fresh_text = 1'b1;
        last_label = '0;
        n_texts++;
      end
      if (emit || it.sequence_end) begin
        res.char_index = emit ? label - 1'b1 : '0;
        res.has_char = emit;
        res.text_end = it.sequence_end;
        expected_chars = {expected_chars, res};
      end
    end
  endtask

  // Queues one time step; the last beat closes the step and optionally the text.
  task automatic push_step(input int sc[$], input bit text_done, input bit no_step_end);
    pend_beat_t b;
    foreach (sc[i]) begin
      b.item.score = SCORE_W'(sc[i]);
      b.item.step_end = (i == sc.size() - 1) && !(text_done && no_step_end);
      b.item.sequence_end = (i == sc.size() - 1) && text_done;
      b.hold = hold_next;
      hold_next = 1'b0;
      pending = {pending, b};
    end
    n_total += sc.size();
  endtask

  // Sender: bursts of beats with random gaps; a held beat waits for all results.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_score(in_data);
        n_items++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0 &&
                     (!pending[0].hold || expected_chars.size() == 0)) begin
          in_valid <= 1'b1;
          in_data <= pending[0].item;
          pending.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and stalls on its own changing pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_tick = 0;
      stall_mode = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing expected", out_data));
        end else begin
          exp_r = expected_chars.pop_front();
          if (out_data.char_index !== exp_r.char_index)
            report_mismatch($sformatf("char_index %0d, expected %0d",
                                      out_data.char_index, exp_r.char_index));
          if (out_data.has_char !== exp_r.has_char)
            report_mismatch($sformatf("has_char %b, expected %b",
                                      out_data.has_char, exp_r.has_char));
          if (out_data.text_end !== exp_r.text_end)
            report_mismatch($sformatf("text_end %b, expected %b",
                                      out_data.text_end, exp_r.text_end));
          n_results++;
          if (exp_r.has_char) n_chars++;
        end
      end
      stall_tick++;
      if (stall_tick % 200 == 0) stall_mode = $urandom_range(0, 3);
      unique case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= (stall_tick % 16) < 10;
      endcase
    end
  end

  initial begin
    int sc[$];
    int nsteps;
    int ncls;
    int mode;
    int win;
    int top;
    int prev_win;

    // Directed: extreme scores, ties, blanks, repeats across a blank,
    // and a text closed without a step end.
    push_step('{-32768, 32767}, 1'b0, 1'b0);
    push_step('{5, 5, 5}, 1'b0, 1'b0);
    push_step('{-32768, -32768}, 1'b0, 1'b0);
    push_step('{0, 100}, 1'b0, 1'b0);
    push_step('{0, 100}, 1'b0, 1'b0);
    push_step('{0, 0, 7}, 1'b1, 1'b1);
    push_step('{3, -1}, 1'b1, 1'b0);
    push_step('{1, 2}, 1'b0, 1'b0);
    push_step('{1, 2}, 1'b1, 1'b0);

    hold_next = 1'b1;
    top = n_total + 480;
    while (n_total < top) begin
      if ($urandom_range(0, 19) == 0) hold_next = 1'b1;
      nsteps = $urandom_range(1, 6);
      prev_win = -1;
      for (int s = 0; s < nsteps; s++) begin
        ncls = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        mode = $urandom_range(0, 9);
        sc.delete();
        if (mode < 5) begin
          // A chosen winner, often a repeat of the last one or the blank.
          if (prev_win >= 0 && prev_win < ncls && $urandom_range(0, 2) == 0) win = prev_win;
          else if ($urandom_range(0, 4) == 0) win = 0;
          else win = $urandom_range(0, ncls - 1);
          prev_win = win;
          mode = int'($urandom_range(1, 65535)) - 32768;
          for (int i = 0; i < ncls; i++) begin
            if (i == win) sc = {sc, mode};
            else if (i < win) sc = {sc, int'($urandom_range(0, mode + 32767)) - 32768};
            else sc = {sc, int'($urandom_range(0, mode + 32768)) - 32768};
          end
        end else if (mode < 8) begin
          prev_win = -1;
          for (int i = 0; i < ncls; i++) sc = {sc, int'($urandom_range(0, 65535)) - 32768};
        end else begin
          prev_win = -1;
          for (int i = 0; i < ncls; i++) sc = {sc, int'($urandom_range(0, 2)) - 1};
        end
        push_step(sc, s == nsteps - 1, $urandom_range(0, 7) == 0);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (n_items != n_total) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_chars.size()));

    $display("Sent %0d score beats in %0d texts, with ties, blanks and repeated labels.",
             n_items, n_texts);
    $display("Checked %0d result beats, %0d of them carrying a character.",
             n_results, n_chars);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: run did not finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
